// File: hw/rtl/lpkt_pkg.sv
// Package of types, constants and helpers shared by the key table modules.
package lpkt_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int LIVE_W     = 11;
    localparam int HASH_W     = 21;

    localparam logic [31:0] KEY_INVALID = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_SET     = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BADKEY   = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_DUP      = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       found_value;
        logic [LIVE_W-1:0] live_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] key;
        logic [31:0] value;
    } slot_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        slot_t            wdata;
    } mem_req_t;

    typedef struct packed {
        logic start;
        logic take;
    } seq_cmd_t;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } seq_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } seq_state_t;

    // The table size is a power of two, so the modulo reduces to a truncation.
    function automatic logic [IDX_W-1:0] start_slot(input logic [31:0] key);
        logic [HASH_W-1:0] h;
        h = {key[19:0], 1'b0};
        return IDX_W'(h);
    endfunction

endpackage

// File: hw/rtl/lpkt_slot_ram.sv
// Single-port slot memory with a registered read.
module lpkt_slot_ram (
    input  logic                clk,
    input  lpkt_pkg::mem_req_t  req,
    output lpkt_pkg::slot_t     rdata
);

    lpkt_pkg::slot_t mem [lpkt_pkg::TABLE_SIZE];
    lpkt_pkg::slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lpkt_seq.sv
// Probe sequencer: clearing pass, slot-by-slot probing and table updates.
module lpkt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  lpkt_pkg::seq_cmd_t  cmd,
    input  lpkt_pkg::req_t      item,
    output lpkt_pkg::seq_stat_t stat,
    output lpkt_pkg::rsp_t      res,
    output lpkt_pkg::mem_req_t  mem_req,
    input  lpkt_pkg::slot_t     mem_rdata
);

    localparam logic [lpkt_pkg::IDX_W-1:0] LAST_IDX = lpkt_pkg::IDX_W'(lpkt_pkg::TABLE_SIZE - 1);

    lpkt_pkg::seq_state_t state_reg, state_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [31:0]                  key_reg, key_next;
    logic [31:0]                  val_reg, val_next;
    logic [lpkt_pkg::IDX_W-1:0]   addr_reg, addr_next;
    logic [lpkt_pkg::IDX_W-1:0]   visit_reg, visit_next;
    logic [lpkt_pkg::IDX_W-1:0]   clr_reg, clr_next;
    logic [lpkt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [2:0]                   status_reg, status_next;
    logic [31:0]                  found_reg, found_next;

    logic                         is_set;
    logic                         key_eq;
    logic                         last;
    logic [lpkt_pkg::IDX_W-1:0]   addr_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpkt_pkg::ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        addr_reg   <= addr_next;
        visit_reg  <= visit_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign is_set    = (mem_rdata.state == lpkt_pkg::SLOT_SET);
    assign key_eq    = (mem_rdata.key == key_reg);
    assign last      = (visit_reg == LAST_IDX);
    assign addr_step = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        addr_next     = addr_reg;
        visit_next    = visit_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        mem_req.we    = 1'b0;
        mem_req.addr  = addr_reg;
        mem_req.wdata = '{state: lpkt_pkg::SLOT_EMPTY, key: lpkt_pkg::KEY_INVALID, value: '0};

        case (state_reg)
            lpkt_pkg::ST_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = lpkt_pkg::ST_IDLE;
                end
            end

            lpkt_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    mode_next    = item.mode;
                    key_next     = item.key;
                    val_next     = item.item_value;
                    found_next   = '0;
                    visit_next   = '0;
                    addr_next    = lpkt_pkg::start_slot(item.key);
                    mem_req.addr = addr_next;
                    if (item.key == lpkt_pkg::KEY_INVALID)
                    begin
                        status_next = lpkt_pkg::STAT_BADKEY;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                    else if (item.mode inside {lpkt_pkg::MODE_ADD, lpkt_pkg::MODE_LOOKUP,
                                               lpkt_pkg::MODE_DELETE})
                    begin
                        state_next = lpkt_pkg::ST_PROBE;
                    end
                    else
                    begin
                        status_next = lpkt_pkg::STAT_NOTFOUND;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                end
            end

            lpkt_pkg::ST_PROBE:
            begin
                if (mode_reg == lpkt_pkg::MODE_ADD)
                begin
                    if (is_set && key_eq)
                    begin
                        status_next = lpkt_pkg::STAT_DUP;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                    else if (is_set && last)
                    begin
                        status_next = lpkt_pkg::STAT_FULL;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                    else if (is_set)
                    begin
                        addr_next    = addr_step;
                        visit_next   = visit_reg + 1'b1;
                        mem_req.addr = addr_step;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = '{state: lpkt_pkg::SLOT_SET, key: key_reg,
                                          value: val_reg};
                        count_next    = count_reg + 1'b1;
                        status_next   = lpkt_pkg::STAT_OK;
                        state_next    = lpkt_pkg::ST_DONE;
                    end
                end
                else
                begin
                    if (mem_rdata.state == lpkt_pkg::SLOT_EMPTY)
                    begin
                        status_next = lpkt_pkg::STAT_NOTFOUND;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                    else if (is_set && key_eq && (mode_reg == lpkt_pkg::MODE_LOOKUP ||
                                                  mem_rdata.value == val_reg))
                    begin
                        status_next = lpkt_pkg::STAT_OK;
                        state_next  = lpkt_pkg::ST_DONE;
                        if (mode_reg == lpkt_pkg::MODE_LOOKUP)
                        begin
                            found_next = mem_rdata.value;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.wdata = '{state: lpkt_pkg::SLOT_DELETED,
                                              key: lpkt_pkg::KEY_INVALID, value: '0};
                            count_next    = count_reg - 1'b1;
                        end
                    end
                    else if (last)
                    begin
                        status_next = lpkt_pkg::STAT_NOTFOUND;
                        state_next  = lpkt_pkg::ST_DONE;
                    end
                    else
                    begin
                        addr_next    = addr_step;
                        visit_next   = visit_reg + 1'b1;
                        mem_req.addr = addr_step;
                    end
                end
            end

            lpkt_pkg::ST_DONE:
            begin
                if (cmd.take)
                begin
                    state_next = lpkt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lpkt_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.ready     = (state_reg == lpkt_pkg::ST_IDLE);
    assign stat.res_valid = (state_reg == lpkt_pkg::ST_DONE);

    assign res.status      = status_reg;
    assign res.found_value = found_reg;
    assign res.live_count  = lpkt_pkg::LIVE_W'(count_reg);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lpkt_pkg::CNT_W'(lpkt_pkg::TABLE_SIZE))
        else $error("live count exceeds the table size");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == lpkt_pkg::ST_CLEAR || state_reg == lpkt_pkg::ST_PROBE))
        else $error("slot memory written outside clearing or probing");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == lpkt_pkg::ST_IDLE)
        else $error("word started while the sequencer is busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpkt_pkg::ST_DONE && status_reg == lpkt_pkg::STAT_FULL)
        |-> count_reg == lpkt_pkg::CNT_W'(lpkt_pkg::TABLE_SIZE))
        else $error("table full reported with free slots");
`endif

endmodule

// File: hw/rtl/linear_probe_key_table.sv
// Top level of the linear-probing key table: handshakes, output register and memory.
//
// A key-to-value table of lpkt_pkg::TABLE_SIZE slots with open addressing and
// linear probing; each request word is an add, a lookup, a delete or an unused
// mode and gives exactly one response word. After reset the block clears every
// slot of its memory and holds req_stall high meanwhile. An operation with an
// all-ones key or an unused mode skips the probe; any other probes slot by
// slot, as the single-port slot memory gives one slot per cycle. The response
// waits in an output register, so the next request is taken while it is still
// stalled.
module linear_probe_key_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lpkt_pkg::req_t req_word,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lpkt_pkg::rsp_t rsp_word
);

    lpkt_pkg::seq_cmd_t  cmd;
    lpkt_pkg::seq_stat_t stat;
    lpkt_pkg::rsp_t      res;
    lpkt_pkg::mem_req_t  mem_req;
    lpkt_pkg::slot_t     mem_rdata;

    logic           rsp_valid_reg, rsp_valid_next;
    lpkt_pkg::rsp_t rsp_word_reg;
    logic           load;

    assign req_stall = !stat.ready;
    assign cmd.start = req_valid && stat.ready;
    assign cmd.take  = !rsp_valid_reg || !rsp_stall;
    assign load      = stat.res_valid && cmd.take;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_word_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    lpkt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (req_word),
        .stat      (stat),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    lpkt_slot_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

// File: verif/tb_linear_probe_key_table.sv
// Self-checking testbench for the linear-probing key table with random handshake idling.
module tb_linear_probe_key_table;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [31:0] HASH_MASK   = 32'h000F_FFFF;
    localparam int          HASH_MULT   = 2;
    localparam int          POOL_MAX    = 48;
    localparam int          QUIET_LIMIT = 20000;
    localparam int          SETTLE_CYCLES = lpkt_pkg::TABLE_SIZE + 100;
    localparam int          PHASE_ITEMS = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    lpkt_pkg::req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    lpkt_pkg::rsp_t rsp_word;

    lpkt_pkg::req_t requests_to_send[$];
    lpkt_pkg::rsp_t pending_responses[$];
    logic [31:0]    key_pool[$];
    logic [31:0]    value_pool[$];

    logic [31:0] shadow_key[lpkt_pkg::TABLE_SIZE];
    logic [31:0] shadow_val[lpkt_pkg::TABLE_SIZE];
    logic [1:0]  shadow_state[lpkt_pkg::TABLE_SIZE];
    int unsigned live_entries;
    int unsigned peak_live;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors = 0;
    int n_checked = 0;
    int quiet_cycles = 0;
    int mode_count[4];
    int status_count[8];

    linear_probe_key_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int unsigned home_slot(input logic [31:0] key);
        return ((key & HASH_MASK) * HASH_MULT) % lpkt_pkg::TABLE_SIZE;
    endfunction

    function automatic int find_slot(input logic [31:0] key, input logic [31:0] val,
                                     input bit match_val);
        int unsigned pos;
        int hit;
        int n;
        bit stop;
        hit = -1;
        stop = 1'b0;
        pos = home_slot(key);
        for (n = 0; n < lpkt_pkg::TABLE_SIZE && !stop; n++)
        begin
            if (shadow_state[pos] == lpkt_pkg::SLOT_EMPTY)
                stop = 1'b1;
            else if (shadow_state[pos] == lpkt_pkg::SLOT_SET && shadow_key[pos] == key
                     && (!match_val || shadow_val[pos] == val))
            begin
                hit = pos;
                stop = 1'b1;
            end
            else
                pos = (pos + 1) % lpkt_pkg::TABLE_SIZE;
        end
        return hit;
    endfunction

    function automatic lpkt_pkg::rsp_t predict_table_response(input lpkt_pkg::req_t w);
        lpkt_pkg::rsp_t r;
        int unsigned pos;
        int hit;
        int n;
        bit stop;
        r = '0;
        stop = 1'b0;
        if (w.key == lpkt_pkg::KEY_INVALID)
            r.status = lpkt_pkg::STAT_BADKEY;
        else if (w.mode == lpkt_pkg::MODE_ADD)
        begin
            r.status = lpkt_pkg::STAT_FULL;
            pos = home_slot(w.key);
            for (n = 0; n < lpkt_pkg::TABLE_SIZE && !stop; n++)
            begin
                if (shadow_state[pos] != lpkt_pkg::SLOT_SET)
                begin
                    shadow_key[pos] = w.key;
                    shadow_val[pos] = w.item_value;
                    shadow_state[pos] = lpkt_pkg::SLOT_SET;
                    live_entries++;
                    r.status = lpkt_pkg::STAT_OK;
                    stop = 1'b1;
                end
                else if (shadow_key[pos] == w.key)
                begin
                    r.status = lpkt_pkg::STAT_DUP;
                    stop = 1'b1;
                end
                else
                    pos = (pos + 1) % lpkt_pkg::TABLE_SIZE;
            end
        end
        else if (w.mode == lpkt_pkg::MODE_LOOKUP)
        begin
            hit = find_slot(w.key, '0, 1'b0);
            if (hit >= 0)
            begin
                r.status = lpkt_pkg::STAT_OK;
                r.found_value = shadow_val[hit];
            end
            else
                r.status = lpkt_pkg::STAT_NOTFOUND;
        end
        else if (w.mode == lpkt_pkg::MODE_DELETE)
        begin
            hit = find_slot(w.key, w.item_value, 1'b1);
            if (hit >= 0)
            begin
                shadow_key[hit] = lpkt_pkg::KEY_INVALID;
                shadow_val[hit] = '0;
                shadow_state[hit] = lpkt_pkg::SLOT_DELETED;
                live_entries--;
                r.status = lpkt_pkg::STAT_OK;
            end
            else
                r.status = lpkt_pkg::STAT_NOTFOUND;
        end
        else
            r.status = lpkt_pkg::STAT_NOTFOUND;
        if (live_entries > peak_live)
            peak_live = live_entries;
        r.live_count = lpkt_pkg::LIVE_W'(live_entries);
        return r;
    endfunction

    function automatic lpkt_pkg::req_t random_request();
        lpkt_pkg::req_t w;
        int roll;
        int pick;
        w.item_value = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 4)
            w.item_value = '0;
        else if (roll < 8)
            w.item_value = 32'hFFFF_FFFF;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            w.mode = lpkt_pkg::MODE_ADD;
        else if (roll < 75)
            w.mode = lpkt_pkg::MODE_LOOKUP;
        else if (roll < 96)
            w.mode = lpkt_pkg::MODE_DELETE;
        else
            w.mode = MODE_UNUSED;
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 75)
        begin
            pick = $urandom_range(0, key_pool.size() - 1);
            w.key = key_pool[pick];
            if (w.mode == lpkt_pkg::MODE_DELETE && $urandom_range(0, 99) < 70)
                w.item_value = value_pool[pick];
        end
        else
        begin
            w.key = $urandom();
            if ($urandom_range(0, 99) < 85)
                w.key[19:0] = 20'($urandom_range(0, 63));
            roll = $urandom_range(0, 99);
            if (roll < 3)
                w.key = lpkt_pkg::KEY_INVALID;
            else if (roll < 5)
                w.key = 32'hFFFF_FFFE;
            else if (w.mode == lpkt_pkg::MODE_ADD)
            begin
                key_pool.push_back(w.key);
                value_pool.push_back(w.item_value);
                if (key_pool.size() > POOL_MAX)
                begin
                    pick = $urandom_range(0, POOL_MAX - 1);
                    key_pool.delete(pick);
                    value_pool.delete(pick);
                end
            end
        end
        return w;
    endfunction

    task automatic queue_request(input logic [1:0] mode, input logic [31:0] key,
                                 input logic [31:0] val);
        lpkt_pkg::req_t w;
        w.mode = mode;
        w.key = key;
        w.item_value = val;
        requests_to_send.push_back(w);
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic wait_for_drain();
        while (requests_to_send.size() != 0 || req_valid || pending_responses.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                pending_responses.push_back(predict_table_response(req_word));
                mode_count[req_word.mode]++;
            end
            if (!req_valid || !req_stall)
            begin
                if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_word  <= requests_to_send.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        lpkt_pkg::rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_checked++;
                if (pending_responses.size() == 0)
                    flag_error($sformatf("response word %0d arrived with none expected",
                                         n_checked));
                else
                begin
                    want = pending_responses.pop_front();
                    status_count[want.status]++;
                    if (rsp_word.status !== want.status)
                        flag_error($sformatf("word %0d status: expected %0d, got %0d",
                                             n_checked, want.status, rsp_word.status));
                    if (rsp_word.found_value !== want.found_value)
                        flag_error($sformatf("word %0d found_value: expected %h, got %h",
                                             n_checked, want.found_value,
                                             rsp_word.found_value));
                    if (rsp_word.live_count !== want.live_count)
                        flag_error($sformatf("word %0d live_count: expected %0d, got %0d",
                                             n_checked, want.live_count,
                                             rsp_word.live_count));
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_linear_probe_key_table: errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] fill_keys[lpkt_pkg::TABLE_SIZE];
        logic [31:0] fill_vals[lpkt_pkg::TABLE_SIZE];
        int i;
        for (i = 0; i < lpkt_pkg::TABLE_SIZE; i++)
        begin
            shadow_key[i] = lpkt_pkg::KEY_INVALID;
            shadow_val[i] = '0;
            shadow_state[i] = lpkt_pkg::SLOT_EMPTY;
        end
        live_entries = 0;
        peak_live = 0;
        for (i = 0; i < 4; i++)
            mode_count[i] = 0;
        for (i = 0; i < 8; i++)
            status_count[i] = 0;
        send_idle_pct = 17;
        recv_idle_pct = 73;

        @(negedge clk);
        queue_request(lpkt_pkg::MODE_ADD,    32'h0000_0000, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_ADD,    32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_ADD,    lpkt_pkg::KEY_INVALID, 32'h1234_5678);
        queue_request(lpkt_pkg::MODE_LOOKUP, lpkt_pkg::KEY_INVALID, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, lpkt_pkg::KEY_INVALID, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_ADD,    32'h0010_0000, 32'hA5A5_A5A5);
        queue_request(lpkt_pkg::MODE_ADD,    32'h0000_0000, 32'h0000_0005);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h0010_0000, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, 32'h0000_0000, 32'h0000_0001);
        queue_request(lpkt_pkg::MODE_DELETE, 32'h0000_0000, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h0010_0000, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        // The tombstone is reused and the live copy further on is not seen.
        queue_request(lpkt_pkg::MODE_ADD,    32'h0010_0000, 32'h5A5A_5A5A);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h0010_0000, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, 32'h0010_0000, 32'hA5A5_A5A5);
        queue_request(MODE_UNUSED,           32'h0000_1234, 32'h0000_0000);
        queue_request(MODE_UNUSED,           lpkt_pkg::KEY_INVALID, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_ADD,    32'h000F_FFFF, 32'h8000_0000);
        queue_request(lpkt_pkg::MODE_ADD,    32'h800F_FFFF, 32'h0000_0001);
        // This probe wraps from the top slot back to the bottom of the table.
        queue_request(lpkt_pkg::MODE_ADD,    32'h400F_FFFF, 32'h7FFF_FFFF);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h400F_FFFF, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, 32'h400F_FFFF, 32'h7FFF_FFFF);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h5555_5555, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, 32'hAAAA_AAAA, 32'hFFFF_FFFF);

        repeat (PHASE_ITEMS) requests_to_send.push_back(random_request());
        wait_for_drain();

        send_idle_pct = 73;
        recv_idle_pct = 17;
        repeat (PHASE_ITEMS) requests_to_send.push_back(random_request());
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) requests_to_send.push_back(random_request());
        wait_for_drain();

        // Fill the table until adds are refused, then work on the full table.
        for (i = 0; i < lpkt_pkg::TABLE_SIZE; i++)
        begin
            fill_keys[i] = {12'($urandom()), 20'(i)};
            fill_vals[i] = $urandom();
            queue_request(lpkt_pkg::MODE_ADD, fill_keys[i], fill_vals[i]);
        end
        queue_request(lpkt_pkg::MODE_ADD,    fill_keys[700], 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h0FFF_FFFF, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_DELETE, fill_keys[3], fill_vals[3] ^ 32'h1);
        queue_request(lpkt_pkg::MODE_DELETE, fill_keys[3], fill_vals[3]);
        queue_request(lpkt_pkg::MODE_ADD,    32'h1234_5678, 32'hCAFE_0001);
        queue_request(lpkt_pkg::MODE_ADD,    32'h2345_6789, 32'hCAFE_0002);
        queue_request(lpkt_pkg::MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        queue_request(lpkt_pkg::MODE_LOOKUP, fill_keys[1000], 32'h0000_0000);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_responses.size() != 0)
            flag_error($sformatf("%0d expected responses never arrived",
                                 pending_responses.size()));
        $display("Covered %0d adds, %0d lookups, %0d deletes, %0d unused modes; %0d checked.",
                 mode_count[lpkt_pkg::MODE_ADD], mode_count[lpkt_pkg::MODE_LOOKUP],
                 mode_count[lpkt_pkg::MODE_DELETE], mode_count[MODE_UNUSED], n_checked);
        $display("Status: %0d ok, %0d bad key, %0d missing, %0d dup, %0d full; peak live %0d.",
                 status_count[lpkt_pkg::STAT_OK], status_count[lpkt_pkg::STAT_BADKEY],
                 status_count[lpkt_pkg::STAT_NOTFOUND], status_count[lpkt_pkg::STAT_DUP],
                 status_count[lpkt_pkg::STAT_FULL], peak_live);
        if (n_errors == 0)
            $display("tb_linear_probe_key_table: clean");
        else
            $display("tb_linear_probe_key_table: errors");
        $finish;
    end

endmodule
